>>> hw/rtl/m6502_pkg.sv
// Shared types and constants for the reduced 6502 step block.
// Holds request codes, instruction opcodes, the controller state type and
// the command/status structs between controller and datapath.
package m6502_pkg;

    // request codes on the input channel
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_EXEC  = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // implemented instruction opcodes
    localparam logic [7:0] OPC_LDA_IMM = 8'hA9;
    localparam logic [7:0] OPC_LDA_ZP  = 8'hA5;
    localparam logic [7:0] OPC_LDA_ZPX = 8'hB5;
    localparam logic [7:0] OPC_LDX_IMM = 8'hA2;
    localparam logic [7:0] OPC_LDY_IMM = 8'hA0;
    localparam logic [7:0] OPC_INX     = 8'hE8;
    localparam logic [7:0] OPC_DEX     = 8'hCA;
    localparam logic [7:0] OPC_INY     = 8'hC8;
    localparam logic [7:0] OPC_DEY     = 8'h88;
    localparam logic [7:0] OPC_STA_ABS = 8'h8D;
    localparam logic [7:0] OPC_ADC_IMM = 8'h69;
    localparam logic [7:0] OPC_CPX_IMM = 8'hE0;
    localparam logic [7:0] OPC_JMP_ABS = 8'h4C;
    localparam logic [7:0] OPC_BNE     = 8'hD0;
    localparam logic [7:0] OPC_BEQ     = 8'hF0;

    localparam logic [15:0] PC_RESET = 16'hFFFC;

    // addressing class of an opcode, drives the controller's sequence
    typedef enum logic [2:0] {
        IC_IMPLIED,
        IC_IMM,
        IC_ZP,
        IC_ABS,
        IC_BRANCH,
        IC_BAD
    } t_iclass;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_WAIT,
        ST_OP_WAIT,
        ST_IMPL,
        ST_OPER_WAIT,
        ST_ZP_WAIT,
        ST_LO_WAIT,
        ST_HI_WAIT,
        ST_DONE
    } t_state;

    // memory address source
    typedef enum logic [1:0] {
        AS_IN,
        AS_PC,
        AS_ZP,
        AS_ABS
    } t_asel;

    // memory write data source
    typedef enum logic {
        WS_IN,
        WS_ACC
    } t_wsel;

    typedef struct packed {
        logic  clr_wr;
        logic  mem_req;
        logic  mem_we;
        t_asel asel;
        t_wsel wsel;
        logic  pc_inc;
        logic  req_start;
        logic  ir_load;
        logic  lo_load;
        logic  rd_load;
        logic  set_bad;
        logic  exec;
        logic  out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic       rd_vld;
        logic [7:0] rdata;
        logic [7:0] ir;
        logic       clr_last;
        logic       out_free;
    } t_dp_stat;

    function automatic t_iclass m6502_class(input logic [7:0] opc);
        t_iclass c;
        case (opc)
            OPC_INX, OPC_DEX, OPC_INY, OPC_DEY: c = IC_IMPLIED;
            OPC_LDA_IMM, OPC_LDX_IMM, OPC_LDY_IMM,
            OPC_ADC_IMM, OPC_CPX_IMM:           c = IC_IMM;
            OPC_LDA_ZP, OPC_LDA_ZPX:            c = IC_ZP;
            OPC_STA_ABS, OPC_JMP_ABS:           c = IC_ABS;
            OPC_BNE, OPC_BEQ:                   c = IC_BRANCH;
            default:                            c = IC_BAD;
        endcase
        return c;
    endfunction

endpackage

>>> hw/rtl/m6502_ctrl.sv
// Sequencer for the reduced 6502 step block: runs the memory clear after
// reset, then walks each request through its fetch and execute steps.
// Depends on m6502_pkg; drives the datapath through t_dp_cmd only.
module m6502_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [1:0]         i_opcode,
    output logic               o_ready,
    output m6502_pkg::t_dp_cmd o_cmd,
    input  m6502_pkg::t_dp_stat i_stat
);
    import m6502_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.req_start = 1'b1;
                    case (i_opcode)
                        REQ_WRITE: begin
                            o_cmd.mem_req = 1'b1;
                            o_cmd.mem_we  = 1'b1;
                            o_cmd.asel    = AS_IN;
                            o_cmd.wsel    = WS_IN;
                            n_state       = ST_DONE;
                        end
                        REQ_EXEC: begin
                            o_cmd.mem_req = 1'b1;
                            o_cmd.asel    = AS_PC;
                            o_cmd.pc_inc  = 1'b1;
                            n_state       = ST_OP_WAIT;
                        end
                        REQ_READ: begin
                            o_cmd.mem_req = 1'b1;
                            o_cmd.asel    = AS_IN;
                            n_state       = ST_RD_WAIT;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_RD_WAIT: begin
                if (i_stat.rd_vld) begin
                    o_cmd.rd_load = 1'b1;
                    n_state       = ST_DONE;
                end
            end
            ST_OP_WAIT: begin
                if (i_stat.rd_vld) begin
                    o_cmd.ir_load = 1'b1;
                    case (m6502_class(i_stat.rdata))
                        IC_IMPLIED: n_state = ST_IMPL;
                        IC_IMM, IC_ZP, IC_BRANCH: begin
                            o_cmd.mem_req = 1'b1;
                            o_cmd.asel    = AS_PC;
                            o_cmd.pc_inc  = 1'b1;
                            n_state       = ST_OPER_WAIT;
                        end
                        IC_ABS: begin
                            o_cmd.mem_req = 1'b1;
                            o_cmd.asel    = AS_PC;
                            o_cmd.pc_inc  = 1'b1;
                            n_state       = ST_LO_WAIT;
                        end
                        default: begin
                            o_cmd.set_bad = 1'b1;
                            n_state       = ST_DONE;
                        end
                    endcase
                end
            end
            ST_IMPL: begin
                o_cmd.exec = 1'b1;
                n_state    = ST_DONE;
            end
            ST_OPER_WAIT: begin
                if (i_stat.rd_vld) begin
                    if (m6502_class(i_stat.ir) == IC_ZP) begin
                        // operand is a zero page pointer: go get the byte
                        o_cmd.mem_req = 1'b1;
                        o_cmd.asel    = AS_ZP;
                        n_state       = ST_ZP_WAIT;
                    end else begin
                        o_cmd.exec = 1'b1;
                        n_state    = ST_DONE;
                    end
                end
            end
            ST_ZP_WAIT: begin
                if (i_stat.rd_vld) begin
                    o_cmd.exec = 1'b1;
                    n_state    = ST_DONE;
                end
            end
            ST_LO_WAIT: begin
                if (i_stat.rd_vld) begin
                    o_cmd.lo_load = 1'b1;
                    o_cmd.mem_req = 1'b1;
                    o_cmd.asel    = AS_PC;
                    o_cmd.pc_inc  = 1'b1;
                    n_state       = ST_HI_WAIT;
                end
            end
            ST_HI_WAIT: begin
                if (i_stat.rd_vld) begin
                    if (i_stat.ir == OPC_STA_ABS) begin
                        o_cmd.mem_req = 1'b1;
                        o_cmd.mem_we  = 1'b1;
                        o_cmd.asel    = AS_ABS;
                        o_cmd.wsel    = WS_ACC;
                    end else begin
                        o_cmd.exec = 1'b1;
                    end
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the result register can take the snapshot
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_rdata_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.rd_vld |-> (r_state == ST_RD_WAIT || r_state == ST_OP_WAIT ||
                           r_state == ST_OPER_WAIT || r_state == ST_ZP_WAIT ||
                           r_state == ST_LO_WAIT || r_state == ST_HI_WAIT))
        else $error("read data returned outside a wait state");

    a_no_early_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_valid) |=> !i_stat.rd_vld)
        else $error("read data one cycle after request accept");

endmodule

>>> hw/rtl/m6502_dpath.sv
// Datapath of the reduced 6502 step block: byte memory with address
// reduction stage, architectural registers, ALU and result register.
// Depends on m6502_pkg; controlled through t_dp_cmd from m6502_ctrl.
module m6502_dpath #(
    parameter int MEM_BYTES = 65536
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  m6502_pkg::t_dp_cmd  i_cmd,
    output m6502_pkg::t_dp_stat o_stat,
    input  logic [15:0]         i_address,
    input  logic [7:0]          i_data,
    input  logic                i_ready,
    output logic                o_valid,
    output logic [7:0]          o_acc,
    output logic [7:0]          o_x_index,
    output logic [7:0]          o_y_index,
    output logic [15:0]         o_prog_counter,
    output logic                o_carry,
    output logic                o_zero,
    output logic                o_negative,
    output logic [7:0]          o_read_data,
    output logic                o_unhandled
);
    import m6502_pkg::*;

    localparam int AW         = $clog2(MEM_BYTES);
    localparam int ADDR_SPAN  = 65536;
    localparam int QW         = $clog2(ADDR_SPAN / MEM_BYTES + 1);
    // floor(2^24 / MEM_BYTES): quotient estimate is low by at most one
    localparam int RECIP_I    = (1 << 24) / MEM_BYTES;
    localparam logic [32:0] RECIP  = 33'(RECIP_I);
    localparam logic [16:0] MEM_SZ = 17'(MEM_BYTES);

    logic [7:0] r_mem [MEM_BYTES];

    // architectural state
    logic [7:0]  r_acc, n_acc;
    logic [7:0]  r_x, n_x;
    logic [7:0]  r_y, n_y;
    logic [15:0] r_pc, n_pc;
    logic        r_c, n_c;
    logic        r_z, n_z;
    logic        r_n, n_n;

    logic [7:0]  r_ir;
    logic [7:0]  r_lo;
    logic [7:0]  r_rd;
    logic        r_bad;
    logic [AW-1:0] r_clr_idx;

    // address stage and read return
    logic          r_s1_vld;
    logic          r_s1_we;
    logic [15:0]   r_a;
    logic [QW-1:0] r_q;
    logic [7:0]    r_wd;
    logic          r_rd_vld;
    logic [7:0]    r_rdata;

    logic          r_out_vld;

    logic [15:0]   w_addr;
    logic [7:0]    w_zp;
    logic [32:0]   w_prod;
    logic [16:0]   w_rem;
    logic [16:0]   w_fix;
    logic [AW-1:0] w_idx;
    logic [8:0]    w_sum;
    logic [8:0]    w_diff;
    logic [7:0]    w_res;
    logic          w_upd_zn;
    logic          w_take;

    // address source
    always_comb begin
        w_zp = r_rdata + ((r_ir == OPC_LDA_ZPX) ? r_x : 8'h00);
        case (i_cmd.asel)
            AS_IN:   w_addr = i_address;
            AS_PC:   w_addr = r_pc;
            AS_ZP:   w_addr = {8'h00, w_zp};
            AS_ABS:  w_addr = {r_rdata, r_lo};
            default: w_addr = r_pc;
        endcase
    end

    assign w_prod = 33'(w_addr) * RECIP;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_cmd.mem_req;
            r_rd_vld <= r_s1_vld && !r_s1_we;
        end
        r_s1_we <= i_cmd.mem_we;
        r_a     <= w_addr;
        r_q     <= QW'(w_prod >> 24);
        r_wd    <= (i_cmd.wsel == WS_ACC) ? r_acc : i_data;
    end

    // remainder lands in [0, 2*MEM_BYTES): one correction step
    always_comb begin
        w_rem = {1'b0, r_a} - 17'(r_q) * MEM_SZ;
        w_fix = (w_rem >= MEM_SZ) ? (w_rem - MEM_SZ) : w_rem;
        w_idx = AW'(w_fix);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            r_mem[r_clr_idx] <= 8'h00;
        end else if (r_s1_vld && r_s1_we) begin
            r_mem[w_idx] <= r_wd;
        end
        if (r_s1_vld && !r_s1_we) begin
            r_rdata <= r_mem[w_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_idx <= r_clr_idx + AW'(1);
        end
    end

    // instruction execute
    always_comb begin
        n_acc    = r_acc;
        n_x      = r_x;
        n_y      = r_y;
        n_c      = r_c;
        n_pc     = i_cmd.pc_inc ? (r_pc + 16'd1) : r_pc;
        w_res    = 8'h00;
        w_upd_zn = 1'b0;
        w_sum    = {1'b0, r_acc} + {1'b0, r_rdata} + 9'(r_c);
        w_diff   = {1'b0, r_x} - {1'b0, r_rdata};
        w_take   = (r_ir == OPC_BNE) ? !r_z : r_z;
        if (i_cmd.exec) begin
            case (r_ir)
                OPC_LDA_IMM, OPC_LDA_ZP, OPC_LDA_ZPX: begin
                    n_acc = r_rdata; w_res = r_rdata; w_upd_zn = 1'b1;
                end
                OPC_LDX_IMM: begin
                    n_x = r_rdata; w_res = r_rdata; w_upd_zn = 1'b1;
                end
                OPC_LDY_IMM: begin
                    n_y = r_rdata; w_res = r_rdata; w_upd_zn = 1'b1;
                end
                OPC_INX: begin
                    n_x = r_x + 8'd1; w_res = n_x; w_upd_zn = 1'b1;
                end
                OPC_DEX: begin
                    n_x = r_x - 8'd1; w_res = n_x; w_upd_zn = 1'b1;
                end
                OPC_INY: begin
                    n_y = r_y + 8'd1; w_res = n_y; w_upd_zn = 1'b1;
                end
                OPC_DEY: begin
                    n_y = r_y - 8'd1; w_res = n_y; w_upd_zn = 1'b1;
                end
                OPC_ADC_IMM: begin
                    n_acc = w_sum[7:0]; n_c = w_sum[8];
                    w_res = w_sum[7:0]; w_upd_zn = 1'b1;
                end
                OPC_CPX_IMM: begin
                    n_c = !w_diff[8]; w_res = w_diff[7:0]; w_upd_zn = 1'b1;
                end
                OPC_JMP_ABS: begin
                    n_pc = {r_rdata, r_lo};
                end
                OPC_BNE, OPC_BEQ: begin
                    // signed offset from the byte after the operand
                    if (w_take) begin
                        n_pc = r_pc + {{8{r_rdata[7]}}, r_rdata};
                    end
                end
                default: begin
                end
            endcase
        end
        n_z = w_upd_zn ? (w_res == 8'h00) : r_z;
        n_n = w_upd_zn ? w_res[7] : r_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= 8'h00;
            r_x   <= 8'h00;
            r_y   <= 8'h00;
            r_pc  <= PC_RESET;
            r_c   <= 1'b0;
            r_z   <= 1'b0;
            r_n   <= 1'b0;
        end else begin
            r_acc <= n_acc;
            r_x   <= n_x;
            r_y   <= n_y;
            r_pc  <= n_pc;
            r_c   <= n_c;
            r_z   <= n_z;
            r_n   <= n_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ir_load) begin
            r_ir <= r_rdata;
        end
        if (i_cmd.lo_load) begin
            r_lo <= r_rdata;
        end
        if (i_cmd.req_start) begin
            r_rd  <= 8'h00;
            r_bad <= 1'b0;
        end else begin
            if (i_cmd.rd_load) begin
                r_rd <= r_rdata;
            end
            if (i_cmd.set_bad) begin
                r_bad <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
        if (i_cmd.out_load) begin
            o_acc          <= r_acc;
            o_x_index      <= r_x;
            o_y_index      <= r_y;
            o_prog_counter <= r_pc;
            o_carry        <= r_c;
            o_zero         <= r_z;
            o_negative     <= r_n;
            o_read_data    <= r_rd;
            o_unhandled    <= r_bad;
        end
    end

    assign o_valid = r_out_vld;

    always_comb begin
        o_stat          = '0;
        o_stat.rd_vld   = r_rd_vld;
        o_stat.rdata    = r_rdata;
        o_stat.ir       = r_ir;
        o_stat.clr_last = (r_clr_idx == AW'(MEM_BYTES - 1));
        o_stat.out_free = !r_out_vld || i_ready;
    end

    a_rd_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> $past(i_cmd.mem_req && !i_cmd.mem_we, 2))
        else $error("read return without a read request two cycles back");

    a_clear_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr_wr |-> !r_s1_vld && !i_cmd.mem_req)
        else $error("memory clear overlaps a memory access");

    a_pc_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_pc != $past(r_pc)) |-> $past(i_cmd.pc_inc || i_cmd.exec))
        else $error("program counter moved without increment or execute");

endmodule

>>> hw/rtl/mini_6502_instruction_step.sv
// Reduced 6502 core with private byte memory. After reset the block clears
// its MEM_BYTES memory one byte per cycle and accepts no request until the
// clear is done. A request then writes a byte, reads a byte back or runs
// one instruction at PC, and returns one result snapshot of A, X, Y, PC,
// flags, read byte and the unhandled flag. Every memory access goes through
// one address-reduction stage and the single memory port, so each byte read
// passes the address-reduction register and then the registered memory read
// before its data is back. The next request is accepted in the cycle after
// the result is loaded, even if that result has not been taken yet.
module mini_6502_instruction_step #(
    parameter int MEM_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_acc,
    output logic [7:0]  o_x_index,
    output logic [7:0]  o_y_index,
    output logic [15:0] o_prog_counter,
    output logic        o_carry,
    output logic        o_zero,
    output logic        o_negative,
    output logic [7:0]  o_read_data,
    output logic        o_unhandled
);
    import m6502_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    m6502_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_opcode (i_opcode),
        .o_ready  (o_ready),
        .o_cmd    (w_cmd),
        .i_stat   (w_stat)
    );

    m6502_dpath #(
        .MEM_BYTES (MEM_BYTES)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_address      (i_address),
        .i_data         (i_data),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_acc          (o_acc),
        .o_x_index      (o_x_index),
        .o_y_index      (o_y_index),
        .o_prog_counter (o_prog_counter),
        .o_carry        (o_carry),
        .o_zero         (o_zero),
        .o_negative     (o_negative),
        .o_read_data    (o_read_data),
        .o_unhandled    (o_unhandled)
    );

endmodule
